// File: src/ksq_pkg.sv
package ksq_pkg;

   typedef enum logic [1:0] {
      OP_STASH  = 2'd0,
      OP_EVICT  = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_GATHER = 2'd3
   } ksq_op_type;

   localparam logic CSR_SLOTS_IN_USE  = 1'b0;
   localparam logic CSR_DEPTH_PER_UID = 1'b1;

   localparam int unsigned MAX_RESULTS = 64;
   localparam logic [6:0]  COUNT_SAT   = 7'd127;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic [63:0] key_uid;
      logic [31:0] key_frame;
      logic        key_clean;
      logic        write_en;
      logic        kill_en;
   } ksq_cmd_type;

   // scan result accumulated along the row of cells
   typedef struct packed {
      logic        hit;
      logic        uid_eq;
      logic        clean;
      logic [31:0] frame;
   } ksq_acc_type;

endpackage

// File: src/ksq_cell.sv
module ksq_cell #(
   parameter int unsigned IDX = 0,
   parameter int unsigned RW = 6,
   parameter int unsigned CW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ksq_pkg::ksq_cmd_type cmd,
   input  logic [CW-1:0]        scan_rank,
   input  logic [RW-1:0]        kill_rank,
   input  logic [RW-1:0]        write_rank,
   input  logic                 in_range,
   input  logic                 free_in,
   input  logic [RW-1:0]        free_idx_in,
   input  ksq_pkg::ksq_acc_type acc_in,
   input  logic [RW-1:0]        acc_slot_in,
   output logic                 free_out,
   output logic [RW-1:0]        free_idx_out,
   output ksq_pkg::ksq_acc_type acc_out,
   output logic [RW-1:0]        acc_slot_out
);
   import ksq_pkg::*;

   localparam logic [RW-1:0] MY_IDX = RW'(IDX);

   logic          live_ff;
   logic [RW-1:0] rank_ff;
   logic [63:0]   uid_ff;
   logic [31:0]   frame_ff;
   logic          clean_ff;

   logic is_free;
   logic sel;
   logic hit;

   assign is_free = !live_ff && in_range;
   // lowest free slot wins: a free cell below blocks this one
   assign sel = is_free && !free_in;
   assign free_out = free_in || is_free;
   assign free_idx_out = free_in ? free_idx_in : MY_IDX;

   assign hit = live_ff && (CW'(rank_ff) == scan_rank);

   always_comb begin
      acc_out.hit    = acc_in.hit | hit;
      acc_out.uid_eq = acc_in.uid_eq | (hit && (uid_ff == cmd.key_uid));
      acc_out.clean  = acc_in.clean | (hit && clean_ff);
      acc_out.frame  = acc_in.frame | (hit ? frame_ff : 32'd0);
      acc_slot_out   = acc_slot_in | (hit ? MY_IDX : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else if (cmd.write_en && sel) begin
         live_ff <= 1'b1;
      end else if (cmd.kill_en && live_ff && rank_ff == kill_rank) begin
         live_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en && sel) begin
         rank_ff  <= write_rank;
         uid_ff   <= cmd.key_uid;
         frame_ff <= cmd.key_frame;
         clean_ff <= cmd.key_clean;
      end else if (cmd.kill_en && live_ff && rank_ff > kill_rank) begin
         rank_ff <= rank_ff - RW'(1);
      end
   end

endmodule

// File: src/keyed_slot_store_lru_quota_unit.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  operation, uid, frame_number, clean_mark, only_clean
// rsp      out        rsp_valid/rsp_ready  result_slot .. last, one or more per request
// csr      in         csr_write_enable     csr_index, csr_write_data
//
// one request at a time; each pass walks the age ranks, one rank per cycle
// stash: scan, quota, write, reply; lookup/evict: scan, reply; gather: scan, one rank a cycle
// the per-rank step is the compare in every cell and the or-chain along the row of cells
// reset (synchronous) clears all live bits and sets slots_in_use 64, depth_per_uid 4
// a stalled response holds the walk; a new request waits in the idle state
module keyed_slot_store_lru_quota_unit #(
   parameter int unsigned SLOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [63:0]        req_uid,
   input  logic signed [31:0] req_frame_number,
   input  logic               req_clean_mark,
   input  logic               req_only_clean,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_result_slot,
   output logic               rsp_slot_valid,
   output logic signed [31:0] rsp_result_frame,
   output logic               rsp_evicted_valid,
   output logic [5:0]         rsp_evicted_slot,
   output logic [6:0]         rsp_uid_count,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [6:0]         csr_write_data
);
   import ksq_pkg::*;

   localparam int unsigned RW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam int unsigned EW = (CW > 7) ? CW : 7;
   localparam int unsigned QMAX = (SLOTS < MAX_RESULTS) ? SLOTS : MAX_RESULTS;

   typedef enum logic [2:0] {
      IDLE, SCAN, QUOTA, FREE1, FREE2, EVSCAN, RESP, GATHER
   } state_type;

   state_type     state_ff, state_in;
   ksq_op_type    op_ff, op_in;
   logic [63:0]   uid_ff, uid_in;
   logic [31:0]   frame_ff, frame_in;
   logic          clean_ff, clean_in;
   logic          co_ff, co_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] live_ff, live_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] qcnt_ff, qcnt_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic          old_found_ff, old_found_in;
   logic [RW-1:0] old_rank_ff, old_rank_in;
   logic [RW-1:0] old_slot_ff, old_slot_in;
   logic          look_found_ff, look_found_in;
   logic          p_valid_ff, p_valid_in;
   logic [RW-1:0] p_slot_ff, p_slot_in;
   logic [31:0]   p_frame_ff, p_frame_in;
   logic          ev_valid_ff, ev_valid_in;
   logic [RW-1:0] ev_slot_ff, ev_slot_in;
   logic [6:0]    slots_cfg_ff, slots_cfg_in;
   logic [6:0]    depth_cfg_ff, depth_cfg_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [5:0]    rsp_slot_ff, rsp_slot_in;
   logic          rsp_sv_ff, rsp_sv_in;
   logic [31:0]   rsp_frame_ff, rsp_frame_in;
   logic          rsp_ev_ff, rsp_ev_in;
   logic [5:0]    rsp_evs_ff, rsp_evs_in;
   logic [6:0]    rsp_cnt_ff, rsp_cnt_in;
   logic          rsp_last_ff, rsp_last_in;

   ksq_cmd_type   cmd;
   logic [CW-1:0] scan_rank;
   logic [RW-1:0] kill_rank;
   logic [6:0]    eff_depth;
   logic [6:0]    n7;
   logic [EW-1:0] eff_n;
   logic [SLOTS-1:0] in_range;

   logic          free_w [SLOTS+1];
   logic [RW-1:0] free_idx_w [SLOTS+1];
   ksq_acc_type   acc_w [SLOTS+1];
   logic [RW-1:0] acc_slot_w [SLOTS+1];

   logic          hit_key;
   logic          qual;
   logic          can_load;
   logic          any_free;
   logic          is_last;
   logic [6:0]    cnt_sat;
   logic [CW+6:0] cnt_wide;
   logic [RW+5:0] slot_wide;
   logic [RW+5:0] p_slot_wide;
   logic [RW+5:0] ev_slot_wide;

   assign eff_depth = (depth_cfg_ff == 7'd0) ? 7'd1 : depth_cfg_ff;
   assign n7 = (slots_cfg_ff < eff_depth) ? eff_depth : slots_cfg_ff;
   assign eff_n = (EW'(n7) > EW'(SLOTS)) ? EW'(SLOTS) : EW'(n7);

   assign free_w[0] = 1'b0;
   assign free_idx_w[0] = '0;
   assign acc_w[0] = '0;
   assign acc_slot_w[0] = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      assign in_range[i] = EW'(i) < eff_n;
      ksq_cell #(
         .IDX   (i),
         .RW    (RW),
         .CW    (CW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .scan_rank    (scan_rank),
         .kill_rank    (kill_rank),
         .write_rank   (live_ff[RW-1:0]),
         .in_range     (in_range[i]),
         .free_in      (free_w[i]),
         .free_idx_in  (free_idx_w[i]),
         .acc_in       (acc_w[i]),
         .acc_slot_in  (acc_slot_w[i]),
         .free_out     (free_w[i+1]),
         .free_idx_out (free_idx_w[i+1]),
         .acc_out      (acc_w[i+1]),
         .acc_slot_out (acc_slot_w[i+1])
      );
   end

   assign any_free = free_w[SLOTS];
   // evict walks downward and looks one rank below the counter
   assign scan_rank = (state_ff == EVSCAN) ? scan_ff - CW'(1) : scan_ff;
   assign hit_key = acc_w[SLOTS].hit && acc_w[SLOTS].uid_eq;
   assign qual = !co_ff || acc_w[SLOTS].clean;
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign is_last = (emit_ff == qcnt_ff - CW'(1));

   assign cnt_wide = {7'd0, cnt_ff};
   assign cnt_sat = (cnt_wide > (CW+7)'(COUNT_SAT)) ? COUNT_SAT : cnt_wide[6:0];
   assign slot_wide = {6'd0, acc_slot_w[SLOTS]};
   assign p_slot_wide = {6'd0, p_slot_ff};
   assign ev_slot_wide = {6'd0, ev_slot_ff};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      uid_in        = uid_ff;
      frame_in      = frame_ff;
      clean_in      = clean_ff;
      co_in         = co_ff;
      scan_in       = scan_ff;
      live_in       = live_ff;
      cnt_in        = cnt_ff;
      qcnt_in       = qcnt_ff;
      emit_in       = emit_ff;
      old_found_in  = old_found_ff;
      old_rank_in   = old_rank_ff;
      old_slot_in   = old_slot_ff;
      look_found_in = look_found_ff;
      p_valid_in    = p_valid_ff;
      p_slot_in     = p_slot_ff;
      p_frame_in    = p_frame_ff;
      ev_valid_in   = ev_valid_ff;
      ev_slot_in    = ev_slot_ff;
      slots_cfg_in  = slots_cfg_ff;
      depth_cfg_in  = depth_cfg_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_sv_in     = rsp_sv_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evs_in    = rsp_evs_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_last_in   = rsp_last_ff;

      cmd.key_uid   = uid_ff;
      cmd.key_frame = frame_ff;
      cmd.key_clean = clean_ff;
      cmd.write_en  = 1'b0;
      cmd.kill_en   = 1'b0;
      kill_rank     = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SLOTS_IN_USE:  slots_cfg_in = csr_write_data;
            CSR_DEPTH_PER_UID: depth_cfg_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               op_in         = ksq_op_type'(req_operation);
               uid_in        = req_uid;
               frame_in      = req_frame_number;
               clean_in      = req_clean_mark;
               co_in         = req_only_clean;
               cnt_in        = '0;
               qcnt_in       = '0;
               old_found_in  = 1'b0;
               look_found_in = 1'b0;
               p_valid_in    = 1'b0;
               p_slot_in     = '0;
               p_frame_in    = '0;
               ev_valid_in   = 1'b0;
               ev_slot_in    = '0;
               if (ksq_op_type'(req_operation) == OP_EVICT) begin
                  scan_in  = live_ff;
                  state_in = EVSCAN;
               end else begin
                  scan_in  = '0;
                  state_in = SCAN;
               end
            end
         end
         SCAN: begin
            if (scan_ff == live_ff) begin
               scan_in = '0;
               emit_in = '0;
               case (op_ff)
                  OP_STASH:  state_in = QUOTA;
                  OP_GATHER: state_in = (qcnt_ff == '0) ? RESP : GATHER;
                  default:   state_in = RESP;
               endcase
            end else begin
               scan_in = scan_ff + CW'(1);
               if (hit_key) begin
                  cnt_in = cnt_ff + CW'(1);
                  if (!old_found_ff) begin
                     old_found_in = 1'b1;
                     old_rank_in  = scan_ff[RW-1:0];
                     old_slot_in  = acc_slot_w[SLOTS];
                  end
                  if (qual) begin
                     if (op_ff == OP_LOOKUP && !look_found_ff &&
                         acc_w[SLOTS].frame == frame_ff) begin
                        look_found_in = 1'b1;
                        p_valid_in    = 1'b1;
                        p_slot_in     = acc_slot_w[SLOTS];
                        p_frame_in    = acc_w[SLOTS].frame;
                     end
                     if (qcnt_ff != CW'(QMAX)) begin
                        qcnt_in = qcnt_ff + CW'(1);
                     end
                  end
               end
            end
         end
         QUOTA: begin
            // quota drop of the key's oldest entry
            if (EW'(cnt_ff) >= EW'(eff_depth) && old_found_ff) begin
               cmd.kill_en = 1'b1;
               kill_rank   = old_rank_ff;
               ev_valid_in = 1'b1;
               ev_slot_in  = old_slot_ff;
               cnt_in      = cnt_ff - CW'(1);
               live_in     = live_ff - CW'(1);
            end
            state_in = FREE1;
         end
         FREE1: begin
            if (any_free) begin
               cmd.write_en = 1'b1;
               live_in      = live_ff + CW'(1);
               cnt_in       = cnt_ff + CW'(1);
               p_valid_in   = 1'b1;
               p_slot_in    = free_idx_w[SLOTS];
               p_frame_in   = frame_ff;
               state_in     = RESP;
            end else if (live_ff != '0) begin
               // global oldest sits at rank zero, which the scan counter points at
               cmd.kill_en = 1'b1;
               kill_rank   = '0;
               ev_valid_in = 1'b1;
               ev_slot_in  = acc_slot_w[SLOTS];
               if (acc_w[SLOTS].uid_eq) begin
                  cnt_in = cnt_ff - CW'(1);
               end
               live_in  = live_ff - CW'(1);
               state_in = FREE2;
            end else begin
               state_in = RESP;
            end
         end
         FREE2: begin
            if (any_free) begin
               cmd.write_en = 1'b1;
               live_in      = live_ff + CW'(1);
               cnt_in       = cnt_ff + CW'(1);
               p_valid_in   = 1'b1;
               p_slot_in    = free_idx_w[SLOTS];
               p_frame_in   = frame_ff;
            end
            state_in = RESP;
         end
         EVSCAN: begin
            if (scan_ff == '0) begin
               state_in = RESP;
            end else begin
               scan_in = scan_ff - CW'(1);
               if (hit_key) begin
                  cmd.kill_en = 1'b1;
                  kill_rank   = scan_rank[RW-1:0];
                  live_in     = live_ff - CW'(1);
               end
            end
         end
         RESP: begin
            if (can_load) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = p_valid_ff ? p_slot_wide[5:0] : 6'd0;
               rsp_sv_in    = p_valid_ff;
               rsp_frame_in = p_valid_ff ? p_frame_ff : 32'd0;
               rsp_ev_in    = ev_valid_ff;
               rsp_evs_in   = ev_valid_ff ? ev_slot_wide[5:0] : 6'd0;
               rsp_cnt_in   = (op_ff == OP_EVICT) ? 7'd0 : cnt_sat;
               rsp_last_in  = 1'b1;
               state_in     = IDLE;
            end
         end
         GATHER: begin
            if (hit_key && qual) begin
               if (can_load) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = slot_wide[5:0];
                  rsp_sv_in    = 1'b1;
                  rsp_frame_in = acc_w[SLOTS].frame;
                  rsp_ev_in    = 1'b0;
                  rsp_evs_in   = 6'd0;
                  rsp_cnt_in   = cnt_sat;
                  rsp_last_in  = is_last;
                  emit_in      = emit_ff + CW'(1);
                  scan_in      = scan_ff + CW'(1);
                  if (is_last) begin
                     state_in = IDLE;
                  end
               end
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         slots_cfg_ff <= 7'd64;
         depth_cfg_ff <= 7'd4;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         slots_cfg_ff <= slots_cfg_in;
         depth_cfg_ff <= depth_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      uid_ff        <= uid_in;
      frame_ff      <= frame_in;
      clean_ff      <= clean_in;
      co_ff         <= co_in;
      scan_ff       <= scan_in;
      cnt_ff        <= cnt_in;
      qcnt_ff       <= qcnt_in;
      emit_ff       <= emit_in;
      old_found_ff  <= old_found_in;
      old_rank_ff   <= old_rank_in;
      old_slot_ff   <= old_slot_in;
      look_found_ff <= look_found_in;
      p_valid_ff    <= p_valid_in;
      p_slot_ff     <= p_slot_in;
      p_frame_ff    <= p_frame_in;
      ev_valid_ff   <= ev_valid_in;
      ev_slot_ff    <= ev_slot_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_sv_ff     <= rsp_sv_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evs_ff    <= rsp_evs_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready         = (state_ff == IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_slot   = rsp_slot_ff;
   assign rsp_slot_valid    = rsp_sv_ff;
   assign rsp_result_frame  = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_slot  = rsp_evs_ff;
   assign rsp_uid_count     = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      EW'(live_ff) <= EW'(SLOTS))
      else $error("live count above pool size");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |=> live_ff == $past(live_ff) + CW'(1))
      else $error("slot write did not bump live count");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      any_free |-> EW'(free_idx_w[SLOTS]) < eff_n)
      else $error("free slot outside the slots in use");

   a_gather_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == GATHER) |-> (scan_ff < live_ff) && (emit_ff < qcnt_ff))
      else $error("gather walk ran past the live ranks");

endmodule
